// ===== rtl/core/ests_pkg.sv =====
package ests_pkg;

   // Screen geometry.
   localparam int SCREEN_ROWS = 10;
   localparam int SCREEN_COLS = 10;

   // Index widths for a row of the screen store and a cell within a row.
   localparam int ROW_AW = $clog2(SCREEN_ROWS);
   localparam int COL_AW = $clog2(SCREEN_COLS);

   // Width of the cursor fields as they appear on the ports.
   localparam int CUR_W = 4;

   // Operation codes.
   localparam logic [1:0] OP_FEED  = 2'd0;
   localparam logic [1:0] OP_CLEAR = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   // Escape parser states.
   localparam logic [1:0] PHASE_IDLE  = 2'd0;
   localparam logic [1:0] PHASE_CARET = 2'd1;
   localparam logic [1:0] PHASE_DIGIT = 2'd2;

   // Character codes of the control stream.
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
   localparam logic [7:0] CHAR_CARET   = 8'h5E;
   localparam logic [7:0] CHAR_B       = 8'h62;
   localparam logic [7:0] CHAR_C       = 8'h63;
   localparam logic [7:0] CHAR_D       = 8'h64;
   localparam logic [7:0] CHAR_E       = 8'h65;
   localparam logic [7:0] CHAR_H       = 8'h68;
   localparam logic [7:0] CHAR_I       = 8'h69;
   localparam logic [7:0] CHAR_L       = 8'h6C;
   localparam logic [7:0] CHAR_O       = 8'h6F;
   localparam logic [7:0] CHAR_R       = 8'h72;
   localparam logic [7:0] CHAR_U       = 8'h75;

   typedef logic [7:0] cell_type;
   typedef cell_type [SCREEN_COLS-1:0] row_type;

   localparam row_type BLANK_ROW = '{default: CHAR_SPACE};

   typedef struct packed {
      logic [1:0]       operation;
      logic [7:0]       char_code;
      logic [CUR_W-1:0] read_row;
      logic [CUR_W-1:0] read_col;
   } req_type;

   typedef struct packed {
      logic [7:0]       read_char;
      logic [CUR_W-1:0] cursor_row;
      logic [CUR_W-1:0] cursor_col;
      logic             insert_on;
   } rsp_type;

   typedef struct packed {
      logic [CUR_W-1:0] cur_row;
      logic [CUR_W-1:0] cur_col;
      logic             insert_mode;
      logic [1:0]       phase;
      logic [3:0]       pending;
   } ctrl_state_type;

   typedef struct packed {
      logic    write_en;
      logic    clear_all;
      row_type row_data;
   } screen_update_type;

endpackage

// ===== rtl/core/escape_sequence_text_screen_core.sv =====
// Character-cell screen of SCREEN_ROWS x SCREEN_COLS bytes driven by a byte stream with
// caret escapes (cursor moves, row clear and erase, insert and overwrite mode, two-digit
// cursor positioning, caret literal). Each request transaction carries one operation:
// feed a byte, clear the whole screen and home the cursor, or read one cell. Every request
// produces exactly one response transaction that reports the cell read (zero for other
// operations or an out-of-range address) and the cursor and insert mode after the request.
// The block accepts one request per clock cycle while req_stall is low; a request passes
// through the execute register and then the response register. The row store has a
// registered read and is addressed ahead with the cursor row and the read row of the next
// request. A response that waits in its register does not block the next request from
// entering the execute register; req_stall rises only while both the execute register and
// the response register are full and rsp_stall is high. The screen is blank after reset
// and after a clear operation at once: per-row valid flags mark rows that were never
// written since, and such rows read as spaces, so no clearing pass runs.
module escape_sequence_text_screen_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ests_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ests_pkg::rsp_type rsp_data
);

   // Execute register: the request being worked on.
   logic                        x_valid_ff;
   logic                        x_valid_in;
   ests_pkg::req_type           x_item_ff;

   // Architectural state of the parser and cursor.
   ests_pkg::ctrl_state_type    state_ff;
   ests_pkg::ctrl_state_type    state_in;

   // One flag per row: clear means the row holds only spaces.
   logic [ests_pkg::SCREEN_ROWS-1:0] row_valid_ff;
   logic [ests_pkg::SCREEN_ROWS-1:0] row_valid_in;

   // Last row write, used to bypass the read-before-write behavior of the store.
   logic                        fwd_valid_ff;
   logic [ests_pkg::ROW_AW-1:0] fwd_row_ff;
   ests_pkg::row_type           fwd_data_ff;

   // Response register.
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   ests_pkg::rsp_type           rsp_data_ff;
   ests_pkg::rsp_type           rsp_data_in;

   logic                        accept;
   logic                        fire;
   logic [ests_pkg::ROW_AW-1:0] cur_idx;
   logic [ests_pkg::ROW_AW-1:0] rd_idx;
   logic [ests_pkg::ROW_AW-1:0] ram_a_addr;
   logic [ests_pkg::ROW_AW-1:0] ram_b_addr;
   logic [ests_pkg::CUR_W-1:0]  next_read_row;
   ests_pkg::row_type           ram_a_data;
   ests_pkg::row_type           ram_b_data;
   ests_pkg::row_type           cursor_row_data;
   ests_pkg::row_type           read_row_data;
   ests_pkg::screen_update_type update;
   logic [7:0]                  read_char;

   // The execute stage completes whenever the response register is free or being drained.
   assign fire      = x_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = x_valid_ff && !fire;
   assign accept    = req_valid && !req_stall;

   assign x_valid_in = accept || (x_valid_ff && !fire);

   // Row of the cursor and of the read address for the request now in execute.
   assign cur_idx = state_ff.cur_row[ests_pkg::ROW_AW-1:0];
   assign rd_idx  = (int'(x_item_ff.read_row) < ests_pkg::SCREEN_ROWS) ?
                    x_item_ff.read_row[ests_pkg::ROW_AW-1:0] : '0;

   // The store is addressed ahead: port A with the cursor row that the next
   // request will see, port B with the read row of the next request.
   assign ram_a_addr    = fire ? state_in.cur_row[ests_pkg::ROW_AW-1:0] : cur_idx;
   assign next_read_row = accept ? req_data.read_row : x_item_ff.read_row;
   assign ram_b_addr    = (int'(next_read_row) < ests_pkg::SCREEN_ROWS) ?
                          next_read_row[ests_pkg::ROW_AW-1:0] : '0;

   ests_ram #(
      .WIDTH($bits(ests_pkg::row_type)),
      .DEPTH(ests_pkg::SCREEN_ROWS)
   ) u_rows (
      .clock     (clock),
      .wr_en     (fire && update.write_en),
      .wr_addr   (cur_idx),
      .wr_data   (update.row_data),
      .rd_a_addr (ram_a_addr),
      .rd_a_data (ram_a_data),
      .rd_b_addr (ram_b_addr),
      .rd_b_data (ram_b_data)
   );

   // A row never written since the last clear reads as spaces; a row written at the
   // previous edge is taken from the bypass register, since the store returned old data.
   always_comb begin
      if (!row_valid_ff[cur_idx]) begin
         cursor_row_data = ests_pkg::BLANK_ROW;
      end else if (fwd_valid_ff && (fwd_row_ff == cur_idx)) begin
         cursor_row_data = fwd_data_ff;
      end else begin
         cursor_row_data = ram_a_data;
      end
      if (!row_valid_ff[rd_idx]) begin
         read_row_data = ests_pkg::BLANK_ROW;
      end else if (fwd_valid_ff && (fwd_row_ff == rd_idx)) begin
         read_row_data = fwd_data_ff;
      end else begin
         read_row_data = ram_b_data;
      end
   end

   ests_step u_step (
      .item            (x_item_ff),
      .state           (state_ff),
      .cursor_row_data (cursor_row_data),
      .read_row_data   (read_row_data),
      .state_next      (state_in),
      .update          (update),
      .read_char       (read_char)
   );

   // A clear operation drops every row flag at once; a row write sets its own flag.
   always_comb begin
      row_valid_in = row_valid_ff;
      if (fire && update.clear_all) begin
         row_valid_in = '0;
      end else if (fire && update.write_en) begin
         row_valid_in[cur_idx] = 1'b1;
      end
   end

   assign rsp_data_in.read_char  = read_char;
   assign rsp_data_in.cursor_row = state_in.cur_row;
   assign rsp_data_in.cursor_col = state_in.cur_col;
   assign rsp_data_in.insert_on  = state_in.insert_mode;

   assign rsp_valid_in = fire || (rsp_valid_ff && rsp_stall);

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         x_valid_ff           <= 1'b0;
         rsp_valid_ff         <= 1'b0;
         fwd_valid_ff         <= 1'b0;
         row_valid_ff         <= '0;
         state_ff.cur_row     <= '0;
         state_ff.cur_col     <= '0;
         state_ff.insert_mode <= 1'b0;
         state_ff.phase       <= ests_pkg::PHASE_IDLE;
         state_ff.pending     <= '0;
      end else begin
         x_valid_ff   <= x_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         fwd_valid_ff <= fire && update.write_en;
         row_valid_ff <= row_valid_in;
         if (fire) begin
            state_ff <= state_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         x_item_ff <= req_data;
      end
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
         fwd_row_ff  <= cur_idx;
         fwd_data_ff <= update.row_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/core/ests_ram.sv =====
module ests_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_a_addr,
   output logic [WIDTH-1:0]         rd_a_data,
   input  logic [$clog2(DEPTH)-1:0] rd_b_addr,
   output logic [WIDTH-1:0]         rd_b_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_data_ff;
   logic [WIDTH-1:0] rd_b_data_ff;

   // Reads return the contents from before a write to the same address.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_data_ff <= mem_ff[rd_a_addr];
      rd_b_data_ff <= mem_ff[rd_b_addr];
   end

   assign rd_a_data = rd_a_data_ff;
   assign rd_b_data = rd_b_data_ff;

endmodule

// ===== rtl/core/ests_step.sv =====
module ests_step (
   input  ests_pkg::req_type           item,
   input  ests_pkg::ctrl_state_type    state,
   input  ests_pkg::row_type           cursor_row_data,
   input  ests_pkg::row_type           read_row_data,
   output ests_pkg::ctrl_state_type    state_next,
   output ests_pkg::screen_update_type update,
   output logic [7:0]                  read_char
);

   logic                           is_digit;
   logic [3:0]                     digit_val;
   logic                           do_put;
   logic                           do_fill;
   logic                           do_clear;
   logic [ests_pkg::COL_AW-1:0]    fill_from;
   logic [ests_pkg::COL_AW-1:0]    cur_idx;
   ests_pkg::row_type              put_row;
   ests_pkg::row_type              fill_row;

   function automatic logic [ests_pkg::CUR_W-1:0] sat_row(input logic [3:0] v);
      return (int'(v) < ests_pkg::SCREEN_ROWS) ? ests_pkg::CUR_W'(v)
                                                : ests_pkg::CUR_W'(ests_pkg::SCREEN_ROWS - 1);
   endfunction

   function automatic logic [ests_pkg::CUR_W-1:0] sat_col(input logic [3:0] v);
      return (int'(v) < ests_pkg::SCREEN_COLS) ? ests_pkg::CUR_W'(v)
                                                : ests_pkg::CUR_W'(ests_pkg::SCREEN_COLS - 1);
   endfunction

   assign is_digit  = (item.char_code >= ests_pkg::CHAR_DIGIT_0) &&
                      (item.char_code <= ests_pkg::CHAR_DIGIT_9);
   assign digit_val = item.char_code[3:0];
   assign cur_idx   = state.cur_col[ests_pkg::COL_AW-1:0];

   // Decode of the operation and the escape parser.
   always_comb begin
      state_next = state;
      do_put     = 1'b0;
      do_fill    = 1'b0;
      do_clear   = 1'b0;
      fill_from  = '0;
      read_char  = '0;
      unique case (item.operation)
         ests_pkg::OP_FEED: begin
            unique case (state.phase)
               ests_pkg::PHASE_DIGIT: begin
                  state_next.phase = ests_pkg::PHASE_IDLE;
                  if (is_digit) begin
                     state_next.cur_row = sat_row(state.pending);
                     state_next.cur_col = sat_col(digit_val);
                  end else if (item.char_code == ests_pkg::CHAR_CARET) begin
                     state_next.phase = ests_pkg::PHASE_CARET;
                  end else begin
                     do_put = 1'b1;
                  end
               end
               ests_pkg::PHASE_CARET: begin
                  state_next.phase = ests_pkg::PHASE_IDLE;
                  case (item.char_code)
                     ests_pkg::CHAR_B: state_next.cur_col = '0;
                     ests_pkg::CHAR_C: begin
                        do_fill   = 1'b1;
                        fill_from = '0;
                     end
                     ests_pkg::CHAR_D: begin
                        if (int'(state.cur_row) < ests_pkg::SCREEN_ROWS - 1) begin
                           state_next.cur_row = state.cur_row + 1'b1;
                        end
                     end
                     ests_pkg::CHAR_U: begin
                        if (state.cur_row != '0) begin
                           state_next.cur_row = state.cur_row - 1'b1;
                        end
                     end
                     ests_pkg::CHAR_L: begin
                        if (state.cur_col != '0) begin
                           state_next.cur_col = state.cur_col - 1'b1;
                        end
                     end
                     ests_pkg::CHAR_R: begin
                        if (int'(state.cur_col) < ests_pkg::SCREEN_COLS - 1) begin
                           state_next.cur_col = state.cur_col + 1'b1;
                        end
                     end
                     ests_pkg::CHAR_E: begin
                        do_fill   = 1'b1;
                        fill_from = cur_idx;
                     end
                     ests_pkg::CHAR_H: begin
                        state_next.cur_row = '0;
                        state_next.cur_col = '0;
                     end
                     ests_pkg::CHAR_I:     state_next.insert_mode = 1'b1;
                     ests_pkg::CHAR_O:     state_next.insert_mode = 1'b0;
                     ests_pkg::CHAR_CARET: do_put = 1'b1;
                     default: begin
                        if (is_digit) begin
                           state_next.pending = digit_val;
                           state_next.phase   = ests_pkg::PHASE_DIGIT;
                        end
                     end
                  endcase
               end
               default: begin
                  if (item.char_code == ests_pkg::CHAR_CARET) begin
                     state_next.phase = ests_pkg::PHASE_CARET;
                  end else begin
                     do_put = 1'b1;
                  end
               end
            endcase
            if (do_put && (int'(state.cur_col) < ests_pkg::SCREEN_COLS - 1)) begin
               state_next.cur_col = state.cur_col + 1'b1;
            end
         end
         ests_pkg::OP_CLEAR: begin
            do_clear           = 1'b1;
            state_next.cur_row = '0;
            state_next.cur_col = '0;
            state_next.phase   = ests_pkg::PHASE_IDLE;
            state_next.pending = '0;
         end
         ests_pkg::OP_READ: begin
            if ((int'(item.read_row) < ests_pkg::SCREEN_ROWS) &&
                (int'(item.read_col) < ests_pkg::SCREEN_COLS)) begin
               read_char = read_row_data[item.read_col[ests_pkg::COL_AW-1:0]];
            end
         end
         default: begin
         end
      endcase
   end

   // Cursor row after a printed byte; insert mode shifts the tail right by one cell.
   always_comb begin
      put_row = cursor_row_data;
      if (state.insert_mode) begin
         for (int c = 1; c < ests_pkg::SCREEN_COLS; c++) begin
            if (ests_pkg::COL_AW'(c) > cur_idx) begin
               put_row[c] = cursor_row_data[c-1];
            end
         end
      end
      put_row[cur_idx] = item.char_code;
   end

   // Cursor row after an erase from fill_from to the end of the row.
   always_comb begin
      fill_row = cursor_row_data;
      for (int c = 0; c < ests_pkg::SCREEN_COLS; c++) begin
         if (ests_pkg::COL_AW'(c) >= fill_from) begin
            fill_row[c] = ests_pkg::CHAR_SPACE;
         end
      end
   end

   assign update.clear_all = do_clear;
   assign update.write_en  = do_put || do_fill;
   assign update.row_data  = do_fill ? fill_row : put_row;

endmodule

// ===== rtl/core/ests_checker.sv =====
module ests_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input ests_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input ests_pkg::rsp_type rsp_data
);

   // A stalled response holds its valid and its payload.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled response changed");

   // Requests are only held off while a finished response is waiting.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled while the response side was free");

   // An accepted request is followed by a valid response unless the response side stalls.
   assert property (@(posedge clock) disable iff (reset)
      ((req_valid && !req_stall) ##1 !(rsp_valid && rsp_stall)) |=> rsp_valid)
      else $error("response missing after an accepted request");

   // The cursor never leaves the screen.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((int'(rsp_data.cursor_row) < ests_pkg::SCREEN_ROWS) &&
                     (int'(rsp_data.cursor_col) < ests_pkg::SCREEN_COLS)))
      else $error("cursor outside the screen");

endmodule

bind escape_sequence_text_screen_core ests_checker u_checker (.*);

// ===== tb/screen_checker.sv =====
module screen_checker
   import ests_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      error_count,
   output int      awaited_count
);

   // Private copy of the screen and the parser state.
   cell_type         cells [SCREEN_ROWS][SCREEN_COLS];
   logic [CUR_W-1:0] row_pos;
   logic [CUR_W-1:0] col_pos;
   logic             insert_mode;
   logic [1:0]       phase;
   logic [3:0]       held_digit;

   rsp_type awaited_rsps[$];
   int      fail_tally = 0;

   function automatic void blank_screen();
      for (int r = 0; r < SCREEN_ROWS; r++)
         for (int c = 0; c < SCREEN_COLS; c++)
            cells[r][c] = CHAR_SPACE;
      row_pos = '0;
      col_pos = '0;
      phase = PHASE_IDLE;
      held_digit = '0;
   endfunction

   function automatic void fill_row_from(int r, int from);
      for (int c = from; c < SCREEN_COLS; c++)
         cells[r][c] = CHAR_SPACE;
   endfunction

   // Writes one glyph at the cursor, shifting the row in insert mode.
   function automatic void put_glyph(cell_type code);
      if (insert_mode) begin
         for (int c = SCREEN_COLS - 1; c > col_pos; c--)
            cells[row_pos][c] = cells[row_pos][c - 1];
      end
      cells[row_pos][col_pos] = code;
      if (col_pos < SCREEN_COLS - 1)
         col_pos++;
   endfunction

   function automatic void plain_byte(cell_type code);
      if (code == CHAR_CARET)
         phase = PHASE_CARET;
      else
         put_glyph(code);
   endfunction

   function automatic rsp_type apply_request(req_type item);
      rsp_type    result;
      logic       is_digit;
      logic [3:0] value;
      result = '0;
      is_digit = (item.char_code >= CHAR_DIGIT_0) && (item.char_code <= CHAR_DIGIT_9);
      value = 4'(item.char_code - CHAR_DIGIT_0);
      case (item.operation)
         OP_FEED: begin
            if (phase == PHASE_DIGIT) begin
               phase = PHASE_IDLE;
               if (is_digit) begin
                  row_pos = (held_digit < SCREEN_ROWS) ? held_digit : CUR_W'(SCREEN_ROWS - 1);
                  col_pos = (value < SCREEN_COLS) ? value : CUR_W'(SCREEN_COLS - 1);
               end else begin
                  plain_byte(item.char_code);
               end
            end else if (phase == PHASE_CARET) begin
               phase = PHASE_IDLE;
               case (item.char_code)
                  CHAR_B: col_pos = '0;
                  CHAR_C: fill_row_from(row_pos, 0);
                  CHAR_D: if (row_pos < SCREEN_ROWS - 1) row_pos++;
                  CHAR_U: if (row_pos > 0) row_pos--;
                  CHAR_L: if (col_pos > 0) col_pos--;
                  CHAR_R: if (col_pos < SCREEN_COLS - 1) col_pos++;
                  CHAR_E: fill_row_from(row_pos, col_pos);
                  CHAR_H: begin
                     row_pos = '0;
                     col_pos = '0;
                  end
                  CHAR_I: insert_mode = 1'b1;
                  CHAR_O: insert_mode = 1'b0;
                  CHAR_CARET: put_glyph(CHAR_CARET);
                  default: begin
                     if (is_digit) begin
                        held_digit = value;
                        phase = PHASE_DIGIT;
                     end
                  end
               endcase
            end else begin
               plain_byte(item.char_code);
            end
         end
         OP_CLEAR: blank_screen();
         OP_READ: begin
            if (item.read_row < SCREEN_ROWS && item.read_col < SCREEN_COLS)
               result.read_char = cells[item.read_row][item.read_col];
         end
         default: ;
      endcase
      result.cursor_row = row_pos;
      result.cursor_col = col_pos;
      result.insert_on = insert_mode;
      return result;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         blank_screen();
         insert_mode = 1'b0;
         awaited_rsps.delete();
      end else begin
         // A response always belongs to an earlier request, so it is checked first.
         if (rsp_valid && !rsp_stall) begin
            if (awaited_rsps.size() == 0) begin
               if (fail_tally < 10)
                  $display("%0t: response with nothing outstanding: char %h row %0d col %0d ins %0b",
                           $time, rsp_data.read_char, rsp_data.cursor_row,
                           rsp_data.cursor_col, rsp_data.insert_on);
               fail_tally++;
            end else begin
               want = awaited_rsps.pop_front();
               if (rsp_data.read_char != want.read_char ||
                   rsp_data.cursor_row != want.cursor_row ||
                   rsp_data.cursor_col != want.cursor_col ||
                   rsp_data.insert_on != want.insert_on) begin
                  if (fail_tally < 10)
                     $display("%0t: mismatch: expected char %h row %0d col %0d ins %0b, %s",
                              $time, want.read_char, want.cursor_row, want.cursor_col,
                              want.insert_on,
                              $sformatf("got char %h row %0d col %0d ins %0b",
                                        rsp_data.read_char, rsp_data.cursor_row,
                                        rsp_data.cursor_col, rsp_data.insert_on));
                  fail_tally++;
               end
            end
         end
         if (req_valid && !req_stall)
            awaited_rsps.push_back(apply_request(req_data));
      end
      error_count <= fail_tally;
      awaited_count <= awaited_rsps.size();
   end

endmodule

// ===== tb/escape_sequence_text_screen_core_tb.sv =====
module escape_sequence_text_screen_core_tb;
   import ests_pkg::*;

   // The block leaves operation code 3 unused; it must still be sent and answered.
   localparam logic [1:0] OP_SPARE = 2'd3;

   localparam int ITEM_COUNT  = 500;
   // From this many sent items on, neither side idles any more.
   localparam int CALM_FROM   = 420;
   localparam int CYCLE_LIMIT = 200000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int   error_count;
   int   awaited_count;
   int   sent_count = 0;
   int   cycle_count = 0;
   int   stall_left = 0;
   logic calm = 1'b0;

   always #5 clock = ~clock;

   escape_sequence_text_screen_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // The checker mirrors the screen from the accepted request transactions and
   // compares every response transaction in order.
   screen_checker screen_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .error_count   (error_count),
      .awaited_count (awaited_count)
   );

   // A hung handshake must not keep the simulation alive forever.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("escape_sequence_text_screen_core_tb: errors");
         $finish;
      end
   end

   // The response side stalls in random bursts. Once the run has gone calm, it
   // takes every response at once.
   always @(negedge clock) begin
      if (calm) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(5) == 0) begin
         rsp_stall <= 1'b1;
         stall_left <= $urandom_range(3);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Offers one request transaction and returns at the falling edge after it was
   // taken. The caller is always at a falling edge. A random idle burst may come
   // first; valid then stays low for the whole burst.
   task automatic send_item(input req_type item);
      int gap;
      gap = (!calm && $urandom_range(4) == 0) ? $urandom_range(1, 4) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      sent_count++;
   endtask

   // The fields that an operation ignores still carry random bits, so every bit
   // of every field is exercised.
   task automatic send_feed(input logic [7:0] code);
      req_type item;
      item.operation = OP_FEED;
      item.char_code = code;
      item.read_row = CUR_W'($urandom_range(15));
      item.read_col = CUR_W'($urandom_range(15));
      send_item(item);
   endtask

   task automatic send_cell_read(input logic [CUR_W-1:0] row, input logic [CUR_W-1:0] col);
      req_type item;
      item.operation = OP_READ;
      item.char_code = 8'($urandom_range(255));
      item.read_row = row;
      item.read_col = col;
      send_item(item);
   endtask

   task automatic send_op(input logic [1:0] op);
      req_type item;
      item.operation = op;
      item.char_code = 8'($urandom_range(255));
      item.read_row = CUR_W'($urandom_range(15));
      item.read_col = CUR_W'($urandom_range(15));
      send_item(item);
   endtask

   task automatic send_escape(input logic [7:0] code);
      send_feed(CHAR_CARET);
      send_feed(code);
   endtask

   function automatic logic [7:0] pick_command();
      case ($urandom_range(10))
         0: return CHAR_B;
         1: return CHAR_C;
         2: return CHAR_D;
         3: return CHAR_E;
         4: return CHAR_H;
         5: return CHAR_I;
         6: return CHAR_L;
         7: return CHAR_O;
         8: return CHAR_R;
         9: return CHAR_U;
         default: return CHAR_CARET;
      endcase
   endfunction

   function automatic logic [7:0] pick_digit();
      return CHAR_DIGIT_0 + 8'($urandom_range(9));
   endfunction

   function automatic logic [7:0] pick_non_digit();
      logic [7:0] code;
      do code = 8'($urandom_range(255));
      while (code >= CHAR_DIGIT_0 && code <= CHAR_DIGIT_9);
      return code;
   endfunction

   initial begin
      int pick;
      logic [CUR_W-1:0] row;
      logic [CUR_W-1:0] col;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part. The screen must read as blank right after reset, and the
      // extreme byte values must be stored as they are.
      send_cell_read(4'd0, 4'd0);
      send_feed(8'h00);
      send_feed(8'hFF);
      // A doubled caret prints a caret.
      send_escape(CHAR_CARET);
      // Two digits move the cursor to the far corner, where down and right clamp.
      send_feed(CHAR_CARET);
      send_feed(CHAR_DIGIT_9);
      send_feed(CHAR_DIGIT_9);
      send_escape(CHAR_D);
      send_escape(CHAR_R);
      // A digit followed by a caret drops the digit and starts a new escape.
      send_feed(CHAR_CARET);
      send_feed(CHAR_DIGIT_0 + 8'd5);
      send_escape(CHAR_H);
      // An unknown escape byte is discarded together with its caret.
      send_escape(8'hF0);
      // Insert mode shifts the home row right by one cell.
      send_escape(CHAR_I);
      send_feed(8'h51);
      // Reads outside the screen return zero; the last cell is in range.
      send_cell_read(4'hF, 4'hF);
      send_cell_read(4'd9, 4'd9);
      send_op(OP_SPARE);
      send_op(OP_CLEAR);

      // Random part. Most transactions form well-shaped escapes and text so the
      // cursor and insert mode wander over the whole screen; a few escapes are
      // broken on purpose, and reads check cells that earlier text filled.
      while (sent_count < ITEM_COUNT) begin
         if (sent_count >= CALM_FROM)
            calm <= 1'b1;
         pick = $urandom_range(99);
         if (pick < 30) begin
            send_escape(pick_command());
         end else if (pick < 45) begin
            send_feed(CHAR_CARET);
            send_feed(pick_digit());
            send_feed(pick_digit());
         end else if (pick < 50) begin
            send_feed(CHAR_CARET);
            send_feed(pick_digit());
            send_feed(pick_non_digit());
         end else if (pick < 54) begin
            send_escape(8'($urandom_range(255)));
         end else if (pick < 78) begin
            send_feed(8'($urandom_range(255)));
         end else if (pick < 94) begin
            // Mostly cells on the screen, now and then an address past its edge.
            if ($urandom_range(7) == 0) begin
               row = CUR_W'($urandom_range(15));
               col = CUR_W'($urandom_range(15));
            end else begin
               row = CUR_W'($urandom_range(SCREEN_ROWS - 1));
               col = CUR_W'($urandom_range(SCREEN_COLS - 1));
            end
            send_cell_read(row, col);
         end else if (pick < 97) begin
            send_op(OP_CLEAR);
         end else begin
            send_op(OP_SPARE);
         end
      end
      req_valid <= 1'b0;

      // Wait for the last responses, then leave time for anything stray.
      do @(posedge clock); while (awaited_count != 0);
      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("escape_sequence_text_screen_core_tb: clean");
      else
         $display("escape_sequence_text_screen_core_tb: errors");
      $finish;
   end

endmodule
